/* design/running_stats_accumulator_macros.svh */
// ----------------------------------------------------------------------------
// running_stats_accumulator_macros
// assertion macros shared by the running statistics accumulator
// ----------------------------------------------------------------------------
`ifndef RUNNING_STATS_ACCUMULATOR_MACROS_SVH
`define RUNNING_STATS_ACCUMULATOR_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define RSA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// widths, payload types and per-channel record of the statistics block
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CHAN_BITS    = 3;
   localparam int SAMPLE_BITS  = 20;
   localparam int COUNT_BITS   = 16;
   localparam int FRAC_BITS    = 8;
   localparam int MEAN_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int M2_BITS      = 62;
   localparam int VAR_BITS     = 46;

   typedef struct packed {
      logic [CHAN_BITS-1:0]   channel;
      logic [SAMPLE_BITS-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] min_value;
      logic [COUNT_BITS-1:0]  min_position;
      logic [SAMPLE_BITS-1:0] max_value;
      logic [COUNT_BITS-1:0]  max_position;
      logic [MEAN_BITS-1:0]   mean_fixed;
      logic [VAR_BITS-1:0]    variance_fixed;
      logic [COUNT_BITS-1:0]  sample_count;
      logic                   count_full;
   } rsp_payload_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] least_seen;
      logic [COUNT_BITS-1:0]  least_at;
      logic [SAMPLE_BITS-1:0] greatest_seen;
      logic [COUNT_BITS-1:0]  greatest_at;
      logic [MEAN_BITS-1:0]   mean;
      logic [M2_BITS-1:0]     m2;
      logic [COUNT_BITS-1:0]  count;
   } chan_stats_type;

endpackage

/* design/rsa_req_if.sv */
// ----------------------------------------------------------------------------
// rsa_req_if
// sample channel: valid/ready handshake carrying channel and sample
// ----------------------------------------------------------------------------
interface rsa_req_if;
   import rsa_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/rsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// rsa_rsp_if
// result channel: valid/ready handshake carrying one statistics item
// ----------------------------------------------------------------------------
interface rsa_rsp_if;
   import rsa_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/running_stats_accumulator.sv */
// ----------------------------------------------------------------------------
// running_stats_accumulator
// per-channel min/max, running mean and population variance (Welford)
//
// req_ch takes one item: a channel number and a 20-bit sample. rsp_ch returns
// one item for each: min and max with the sample number at which each was
// set, mean and variance in fixed point with 8 fraction bits, the count and
// a flag for a sample dropped because the channel's count is full.
// One restoring divider, one bit a cycle, does both divisions; a single
// multiplier forms mean*count and the Welford product under a small
// sequencer. An ordinary item passes load, the mean division, difference,
// product, accumulate, the variance division and write back; an item on a
// full channel skips to the variance division, one on an out-of-range
// channel goes to write back with an all-zero result. req_ch.ready is high
// only while the sequencer is idle, so no item is taken until the last one
// is written back. The result sits in an output register: a new item is
// accepted while it waits, and the sequencer holds before write back until
// rsp_ch takes it. Synchronous reset clears every channel (minimum set to
// all ones) at once, and the block is ready once reset is released.
// ----------------------------------------------------------------------------
`include "running_stats_accumulator_macros.svh"

module running_stats_accumulator (
   input  logic       clock,
   input  logic       reset,
   rsa_req_if.sink    req_ch,
   rsa_rsp_if.source  rsp_ch
);
   import rsa_pkg::*;

   localparam int MUL_BITS  = MEAN_BITS + COUNT_BITS + 1;
   localparam int PROD_BITS = 2 * MEAN_BITS;
   localparam int INC_BITS  = PROD_BITS - FRAC_BITS;
   localparam int STEP_BITS = $clog2(M2_BITS);

   // cleared channel record, least_seen is the top field
   localparam chan_stats_type STATS_RESET =
      {{SAMPLE_BITS{1'b1}}, ($bits(chan_stats_type) - SAMPLE_BITS)'(0)};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV_MEAN,
      ST_DIFF,
      ST_MULT,
      ST_ACCUM,
      ST_DIV_VAR,
      ST_WRITE
   } state_type;

   state_type              state_ff, state_in;
   chan_stats_type         stats_ff [NUM_CHANNELS];
   chan_stats_type         stats_in [NUM_CHANNELS];
   logic [CHAN_BITS-1:0]   chan_ff, chan_in;
   logic [SAMPLE_BITS-1:0] samp_ff, samp_in;
   logic                   full_ff, full_in;
   logic                   skip_ff, skip_in;
   logic [MEAN_BITS-1:0]   new_mean_ff, new_mean_in;
   logic [MEAN_BITS-1:0]   d1_ff, d1_in;
   logic [MEAN_BITS-1:0]   d2_ff, d2_in;
   logic [INC_BITS-1:0]    inc_ff, inc_in;
   logic [M2_BITS-1:0]     m2_ff, m2_in;
   logic [M2_BITS-1:0]     dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [COUNT_BITS-1:0]  div_ff, div_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   chan_stats_type                  entry;
   chan_stats_type                  upd;
   chan_stats_type                  src;
   logic [MEAN_BITS-1:0]            sf;
   logic [MEAN_BITS-1:0]            mul_a;
   logic [MEAN_BITS-1:0]            mul_b;
   logic [PROD_BITS-1:0]            mul_out;
   logic [MEAN_BITS+COUNT_BITS-1:0] mean_prod;
   logic [MUL_BITS-1:0]             mean_sum;
   logic [M2_BITS:0]                m2_sum;
   logic [COUNT_BITS:0]             shifted;
   logic [COUNT_BITS:0]             sub;
   logic                            qbit;
   logic                            out_free;
   logic                            out_of_range;
   logic                            is_full;
   logic [VAR_BITS-1:0]             var_sat;
   logic                            accepted;
   logic                            div_busy;
   logic                            mean_spill;

   assign entry        = stats_ff[chan_ff];
   assign sf           = {samp_ff, FRAC_BITS'(0)};
   // shared multiplier: mean*count at load, Welford product afterwards
   assign mul_a        = (state_ff == ST_MULT) ? d1_ff : entry.mean;
   assign mul_b        = (state_ff == ST_MULT) ? d2_ff : MEAN_BITS'(entry.count);
   assign mul_out      = mul_a * mul_b;
   assign mean_prod    = mul_out[MEAN_BITS+COUNT_BITS-1:0];
   assign mean_sum     = MUL_BITS'(mean_prod) + MUL_BITS'(sf);
   assign m2_sum       = {1'b0, m2_ff} + (M2_BITS + 1)'(inc_ff);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign out_of_range = {1'b0, chan_ff} >= (CHAN_BITS + 1)'(NUM_CHANNELS);
   assign is_full      = entry.count == {COUNT_BITS{1'b1}};

   // one restoring divider step
   assign shifted = {rem_ff, dvd_ff[M2_BITS-1]};
   assign sub     = shifted - {1'b0, div_ff};
   assign qbit    = shifted >= {1'b0, div_ff};

   assign var_sat = (|dvd_ff[M2_BITS-1:VAR_BITS]) ? {VAR_BITS{1'b1}}
                                                  : dvd_ff[VAR_BITS-1:0];

   assign req_ch.ready   = (state_ff == ST_IDLE) && !reset;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign accepted   = req_ch.valid && req_ch.ready;
   assign div_busy   = (state_ff == ST_DIV_MEAN) || (state_ff == ST_DIV_VAR);
   assign mean_spill = |dvd_ff[M2_BITS-1:MEAN_BITS];

   // channel record after an accepted sample
   always_comb begin
      upd = entry;
      if (samp_ff < entry.least_seen) begin
         upd.least_seen = samp_ff;
         upd.least_at   = entry.count;
      end
      if (samp_ff > entry.greatest_seen) begin
         upd.greatest_seen = samp_ff;
         upd.greatest_at   = entry.count;
      end
      upd.mean  = new_mean_ff;
      upd.m2    = m2_ff;
      upd.count = entry.count + COUNT_BITS'(1);
   end

   assign src = full_ff ? entry : upd;

   always_comb begin
      state_in     = state_ff;
      stats_in     = stats_ff;
      chan_in      = chan_ff;
      samp_in      = samp_ff;
      full_in      = full_ff;
      skip_in      = skip_ff;
      new_mean_in  = new_mean_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      inc_in       = inc_ff;
      m2_in        = m2_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               chan_in  = req_ch.payload.channel;
               samp_in  = req_ch.payload.sample;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            skip_in = out_of_range;
            full_in = is_full;
            rem_in  = '0;
            if (out_of_range) begin
               state_in = ST_WRITE;
            end else if (is_full) begin
               dvd_in   = entry.m2;
               div_in   = entry.count;
               step_in  = STEP_BITS'(M2_BITS - 1);
               state_in = ST_DIV_VAR;
            end else begin
               // dividend mean*count + sample, top aligned in the divider
               dvd_in   = {mean_sum, (M2_BITS - MUL_BITS)'(0)};
               div_in   = entry.count + COUNT_BITS'(1);
               step_in  = STEP_BITS'(MUL_BITS - 1);
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN, ST_DIV_VAR: begin
            rem_in  = qbit ? sub[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            dvd_in  = {dvd_ff[M2_BITS-2:0], qbit};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = (state_ff == ST_DIV_MEAN) ? ST_DIFF : ST_WRITE;
            end
         end
         ST_DIFF: begin
            // new mean lies between old mean and the sample
            new_mean_in = dvd_ff[MEAN_BITS-1:0];
            d1_in    = (sf >= entry.mean) ? sf - entry.mean : entry.mean - sf;
            d2_in    = (sf >= dvd_ff[MEAN_BITS-1:0]) ? sf - dvd_ff[MEAN_BITS-1:0]
                                                     : dvd_ff[MEAN_BITS-1:0] - sf;
            m2_in    = entry.m2;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            inc_in   = mul_out[PROD_BITS-1:FRAC_BITS];
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            m2_in    = m2_sum[M2_BITS] ? {M2_BITS{1'b1}} : m2_sum[M2_BITS-1:0];
            dvd_in   = m2_sum[M2_BITS] ? {M2_BITS{1'b1}} : m2_sum[M2_BITS-1:0];
            div_in   = entry.count + COUNT_BITS'(1);
            rem_in   = '0;
            step_in  = STEP_BITS'(M2_BITS - 1);
            state_in = ST_DIV_VAR;
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (skip_ff) begin
                  rsp_data_in = '0;
               end else begin
                  if (!full_ff) begin
                     stats_in[chan_ff] = upd;
                  end
                  rsp_data_in.min_value      = src.least_seen;
                  rsp_data_in.min_position   = src.least_at;
                  rsp_data_in.max_value      = src.greatest_seen;
                  rsp_data_in.max_position   = src.greatest_at;
                  rsp_data_in.mean_fixed     = src.mean;
                  rsp_data_in.variance_fixed = var_sat;
                  rsp_data_in.sample_count   = src.count;
                  rsp_data_in.count_full     = full_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            stats_ff[i] <= STATS_RESET;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stats_ff     <= stats_in;
      end
      chan_ff     <= chan_in;
      samp_ff     <= samp_in;
      full_ff     <= full_in;
      skip_ff     <= skip_in;
      new_mean_ff <= new_mean_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      inc_ff      <= inc_in;
      m2_ff       <= m2_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   `RSA_ASSERT_NEXT(a_accept_loads, accepted, state_ff == ST_LOAD, "item did not start a load")
   `RSA_ASSERT_NOW(a_divisor_nonzero, div_busy, div_ff != '0, "divider with zero divisor")
   `RSA_ASSERT_NOW(a_rem_below_divisor, div_busy, rem_ff < div_ff, "remainder too large")
   `RSA_ASSERT_NOW(a_mean_fits, state_ff == ST_DIFF, !mean_spill, "new mean overflows its width")

endmodule
